### src/sct_pkg.sv
// Shared types, constants and the per-cell operation table of the sine/cosine core.
`default_nettype none

package sct_pkg;

   localparam int unsigned DOUBLING_ROUNDS      = 4;
   localparam int unsigned RESULT_FRACTION_BITS = 30;

   localparam int unsigned FracBits   = 60;
   localparam int unsigned AngleShift = 31 - DOUBLING_ROUNDS;
   localparam int unsigned MulStages  = 4;
   // Squaring cell, four polynomial cells, one closing cell, then the doubling cells.
   localparam int unsigned NumCells   = 6 + DOUBLING_ROUNDS;
   localparam int unsigned ResShift   = FracBits - RESULT_FRACTION_BITS;

   localparam logic [63:0] One     = 64'd1 << FracBits;
   localparam logic [63:0] NegOne  = 64'd0 - One;
   localparam logic [63:0] ResHalf = (ResShift > 0) ? (64'd1 << (ResShift - 1)) : 64'd0;

   // Series coefficients, 1/n rounded to the nearest Q3.60 value.
   localparam logic [63:0] KCos0 = (One + 64'd907200) / 64'd1814400;
   localparam logic [63:0] KCos1 = (One + 64'd10080) / 64'd20160;
   localparam logic [63:0] KCos2 = (One + 64'd180) / 64'd360;
   localparam logic [63:0] KCos3 = (One + 64'd6) / 64'd12;
   localparam logic [63:0] KSin0 = (One + 64'd181440) / 64'd362880;
   localparam logic [63:0] KSin1 = (One + 64'd2520) / 64'd5040;
   localparam logic [63:0] KSin2 = (One + 64'd60) / 64'd120;
   localparam logic [63:0] KSin3 = (One + 64'd3) / 64'd6;

   typedef enum logic [1:0] {
      XS_A = 2'd0,
      XS_U = 2'd1,
      XS_W = 2'd2,
      XS_K = 2'd3
   } xsrc_type;

   typedef enum logic [1:0] {
      YS_A   = 2'd0,
      YS_Z   = 2'd1,
      YS_KMU = 2'd2
   } ysrc_type;

   // a: scaled angle, z: its square, u: cosine lane, w: sine lane (all Q3.60).
   typedef struct packed {
      logic [63:0] a;
      logic [63:0] z;
      logic [63:0] u;
      logic [63:0] w;
   } lane_type;

   typedef struct packed {
      xsrc_type    ux_src;
      ysrc_type    uy_src;
      xsrc_type    wx_src;
      ysrc_type    wy_src;
      logic [63:0] u_xk;
      logic [63:0] u_yk;
      logic [63:0] w_xk;
      logic [63:0] w_yk;
      logic [63:0] u_add;
      logic [63:0] w_add;
      logic        to_z;
   } op_type;

   // What each cell of the chain computes; cells past the closing one do doubling.
   function automatic op_type cell_op(input int unsigned level);
      op_type op;
      op.ux_src = XS_U;
      op.uy_src = YS_KMU;
      op.wx_src = XS_W;
      op.wy_src = YS_KMU;
      op.u_xk   = 64'd0;
      op.u_yk   = One << 2;
      op.w_xk   = 64'd0;
      op.w_yk   = One << 1;
      op.u_add  = 64'd0;
      op.w_add  = 64'd0;
      op.to_z   = 1'b0;
      case (level)
         0: begin
            op.ux_src = XS_A;
            op.uy_src = YS_A;
            op.wx_src = XS_A;
            op.wy_src = YS_A;
            op.to_z   = 1'b1;
         end
         1: begin
            op.ux_src = XS_K;
            op.u_xk   = KCos0;
            op.uy_src = YS_Z;
            op.u_add  = 64'd0 - KCos1;
            op.wx_src = XS_K;
            op.w_xk   = KSin0;
            op.wy_src = YS_Z;
            op.w_add  = 64'd0 - KSin1;
         end
         2: begin
            op.uy_src = YS_Z;
            op.u_add  = KCos2;
            op.wy_src = YS_Z;
            op.w_add  = KSin2;
         end
         3: begin
            op.uy_src = YS_Z;
            op.u_add  = 64'd0 - KCos3;
            op.wy_src = YS_Z;
            op.w_add  = 64'd0 - KSin3;
         end
         4: begin
            op.uy_src = YS_Z;
            op.u_add  = One;
            op.wy_src = YS_Z;
            op.w_add  = One;
         end
         5: begin
            op.uy_src = YS_Z;
            op.wy_src = YS_A;
         end
         default: begin
            op.to_z = 1'b0;
         end
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

### src/sct_mul.sv
// Four-stage signed Q3.60 multiplier built from 32x32 partial products, rounded half away from zero.
`default_nettype none

module sct_mul (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] x,
   input  logic [63:0] y,
   output logic [63:0] mag,
   output logic        neg
);
   import sct_pkg::*;

   localparam logic [127:0] RoundBit = 128'd1 << (FracBits - 1);

   logic          neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [63:0]   ma_ff, mb_ff, ma_in, mb_in;
   logic [63:0]   p0_ff, p1_ff, p2_ff, p3_ff;
   logic [63:0]   p0_in, p1_in, p2_in, p3_in;
   logic [64:0]   mid_ff, mid_in;
   logic [127:0]  base_ff, base_in, sum;
   logic [63:0]   r_ff, r_in;

   assign ma_in = x[63] ? (64'd0 - x) : x;
   assign mb_in = y[63] ? (64'd0 - y) : y;

   assign p0_in = 64'(ma_ff[31:0]) * 64'(mb_ff[31:0]);
   assign p1_in = 64'(ma_ff[31:0]) * 64'(mb_ff[63:32]);
   assign p2_in = 64'(ma_ff[63:32]) * 64'(mb_ff[31:0]);
   assign p3_in = 64'(ma_ff[63:32]) * 64'(mb_ff[63:32]);

   assign mid_in  = {1'b0, p1_ff} + {1'b0, p2_ff};
   assign base_in = {p3_ff, p0_ff} + RoundBit;

   assign sum  = base_ff + {31'd0, mid_ff, 32'd0};
   assign r_in = sum[FracBits + 63:FracBits];

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= x[63] ^ y[63];
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         neg2_ff <= neg1_ff;
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         p3_ff   <= p3_in;
         neg3_ff <= neg2_ff;
         mid_ff  <= mid_in;
         base_ff <= base_in;
         neg4_ff <= neg3_ff;
         r_ff    <= r_in;
      end
   end

   assign mag = r_ff;
   assign neg = neg4_ff;

endmodule

`default_nettype wire

### src/sct_cell.sv
// One cell of the chain: operand select, two parallel multipliers and a constant add.
`default_nettype none

module sct_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  sct_pkg::op_type   op,
   input  logic              in_valid,
   input  sct_pkg::lane_type in_lane,
   output logic              out_valid,
   output sct_pkg::lane_type out_lane
);
   import sct_pkg::*;

   localparam int unsigned Depth = MulStages + 1;

   logic [Depth-1:0] valid_ff, valid_in;
   lane_type         lane_ff [Depth];
   logic [63:0]      ux_ff, uy_ff, wx_ff, wy_ff;
   logic [63:0]      ux_in, uy_in, wx_in, wy_in;
   logic [63:0]      u_mag, w_mag, u_res, w_res;
   logic             u_neg, w_neg;
   logic             out_valid_ff;
   lane_type         out_lane_ff, out_lane_in;

   function automatic logic [63:0] pick_x(input xsrc_type src, input lane_type ln,
                                          input logic [63:0] k);
      logic [63:0] v;
      case (src)
         XS_A:    v = ln.a;
         XS_U:    v = ln.u;
         XS_W:    v = ln.w;
         XS_K:    v = k;
         default: v = k;
      endcase
      return v;
   endfunction

   function automatic logic [63:0] pick_y(input ysrc_type src, input lane_type ln,
                                          input logic [63:0] k);
      logic [63:0] v;
      case (src)
         YS_A:    v = ln.a;
         YS_Z:    v = ln.z;
         YS_KMU:  v = k - ln.u;
         default: v = ln.z;
      endcase
      return v;
   endfunction

   assign ux_in = pick_x(op.ux_src, in_lane, op.u_xk);
   assign uy_in = pick_y(op.uy_src, in_lane, op.u_yk);
   assign wx_in = pick_x(op.wx_src, in_lane, op.w_xk);
   assign wy_in = pick_y(op.wy_src, in_lane, op.w_yk);

   assign valid_in = {valid_ff[Depth-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[Depth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff      <= ux_in;
         uy_ff      <= uy_in;
         wx_ff      <= wx_in;
         wy_ff      <= wy_in;
         lane_ff[0] <= in_lane;
         for (int i = 1; i < Depth; i++) begin
            lane_ff[i] <= lane_ff[i-1];
         end
         out_lane_ff <= out_lane_in;
      end
   end

   sct_mul u_mul_u (
      .clock (clock),
      .en    (en),
      .x     (ux_ff),
      .y     (uy_ff),
      .mag   (u_mag),
      .neg   (u_neg)
   );

   sct_mul u_mul_w (
      .clock (clock),
      .en    (en),
      .x     (wx_ff),
      .y     (wy_ff),
      .mag   (w_mag),
      .neg   (w_neg)
   );

   // The sign of the product decides whether its magnitude is added or subtracted.
   assign u_res = u_neg ? (op.u_add - u_mag) : (op.u_add + u_mag);
   assign w_res = w_neg ? (op.w_add - w_mag) : (op.w_add + w_mag);

   always_comb begin
      out_lane_in = lane_ff[Depth-1];
      if (op.to_z) begin
         out_lane_in.z = u_res;
      end else begin
         out_lane_in.u = u_res;
         out_lane_in.w = w_res;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_lane  = out_lane_ff;

endmodule

`default_nettype wire

### src/sct_finish.sv
// Forms the cosine from the doubled versine and clamps both values to plus or minus one.
`default_nettype none

module sct_finish (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [63:0] vers,
   input  logic [63:0] sin_in,
   output logic        out_valid,
   output logic [63:0] cos_out,
   output logic [63:0] sin_out
);
   import sct_pkg::*;

   logic [1:0]  valid_ff;
   logic [63:0] cos1_ff, sin1_ff, cos1_in;
   logic [63:0] cos2_ff, sin2_ff, cos2_in, sin2_in;

   function automatic logic [63:0] clamp(input logic [63:0] v);
      logic [63:0] r;
      if ($signed(v) > $signed(One)) begin
         r = One;
      end else if ($signed(v) < $signed(NegOne)) begin
         r = NegOne;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // cos = 1 - c/2, with c/2 an arithmetic shift.
   assign cos1_in = One - {vers[63], vers[63:1]};
   assign cos2_in = clamp(cos1_ff);
   assign sin2_in = clamp(sin1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos1_ff <= cos1_in;
         sin1_ff <= sin_in;
         cos2_ff <= cos2_in;
         sin2_ff <= sin2_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign cos_out   = cos2_ff;
   assign sin_out   = sin2_ff;

endmodule

`default_nettype wire

### src/sincos_taylor_double_angle_core.sv
// Top level of the sine/cosine core: a chain of multiply cells, a finishing stage and the output word.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | req_angle   (unsigned Q3.29 radians)
//   rsp     | out       | rsp_valid, rsp_stall | rsp_cosine, rsp_sine (signed Q1.30)
//
// One word is accepted per cycle while the chain is not stalled.
// Each cell is six registers deep: operand select, four multiplier stages and the constant add.
// Reset clears only the valid bits of the chain, of the finishing stage and of the output word.
// A stalled output word stops the chain only once its last stage also holds a word.
`default_nettype none

module sincos_taylor_double_angle_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_cosine,
   output logic signed [31:0] rsp_sine
);
   import sct_pkg::*;

   lane_type          chain_lane [NumCells + 1];
   logic [NumCells:0] chain_valid;
   logic              en, rsp_free, rsp_load, last_valid;
   logic [63:0]       fin_cos, fin_sin;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_cos_ff, rsp_sin_ff, rsp_cos_in, rsp_sin_in;

   function automatic logic [31:0] to_field(input logic [63:0] v);
      logic [63:0] t;
      logic [63:0] s;
      t = v + ResHalf;
      s = $signed(t) >>> ResShift;
      return s[31:0];
   endfunction

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign en        = !last_valid || rsp_free;
   assign rsp_load  = last_valid && rsp_free;
   assign req_stall = !en;

   always_comb begin
      chain_lane[0]   = '0;
      chain_lane[0].a = 64'(req_angle) << AngleShift;
   end
   assign chain_valid[0] = req_valid;

   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      sct_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .op        (cell_op(g)),
         .in_valid  (chain_valid[g]),
         .in_lane   (chain_lane[g]),
         .out_valid (chain_valid[g+1]),
         .out_lane  (chain_lane[g+1])
      );
   end

   sct_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (chain_valid[NumCells]),
      .vers      (chain_lane[NumCells].u),
      .sin_in    (chain_lane[NumCells].w),
      .out_valid (last_valid),
      .cos_out   (fin_cos),
      .sin_out   (fin_sin)
   );

   assign rsp_cos_in = to_field(fin_cos);
   assign rsp_sin_in = to_field(fin_sin);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cos_ff <= rsp_cos_in;
         rsp_sin_ff <= rsp_sin_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cosine = rsp_cos_ff;
   assign rsp_sine   = rsp_sin_ff;

endmodule

`default_nettype wire

### src/sct_checker.sv
// Port-level checks of the sine/cosine core and the bind that attaches them.
`default_nettype none

module sct_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [31:0]        req_angle,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_cosine,
   input logic signed [31:0] rsp_sine
);
   import sct_pkg::*;

   localparam int unsigned RangeShift = (RESULT_FRACTION_BITS <= 30) ? RESULT_FRACTION_BITS : 30;
   localparam bit          RangeCheck = (RESULT_FRACTION_BITS <= 30);
   localparam logic signed [31:0] ResMax = 32'sd1 <<< RangeShift;
   localparam logic signed [31:0] ResMin = -ResMax;

   // A stalled input word is held by the sender.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_angle))
      else $error("input word changed while stalled");

   // A waiting output word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cosine) && $stable(rsp_sine))
      else $error("output word changed while stalled");

   // Saturation keeps both results within plus or minus one.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && RangeCheck |->
         rsp_cosine <= ResMax && rsp_cosine >= ResMin && rsp_sine <= ResMax && rsp_sine >= ResMin)
      else $error("result outside plus or minus one");

   // With the output register empty, the input side must never be held off.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output is empty");

   // Reset empties the output register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word present after reset");

endmodule

bind sincos_taylor_double_angle_core sct_checker u_sct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_angle  (req_angle),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_cosine (rsp_cosine),
   .rsp_sine   (rsp_sine)
);

`default_nettype wire
